### src/sbpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpc_pkg
// Types and constants shared by the servo bank pulse controller.
// ----------------------------------------------------------------------------
package sbpc_pkg;

  localparam int unsigned MinMotionMs = 30;
  localparam int unsigned ChanMemW = 72;

  typedef enum logic [1:0] {
    OP_SET_TARGET = 2'd0,
    OP_POWER      = 2'd1,
    OP_RUN_FRAME  = 2'd2,
    OP_UNUSED     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_POWER_OVERRIDE = 2'd0,
    CFG_SERVO_MASK     = 2'd1,
    CFG_END_MARGIN     = 2'd2,
    CFG_NONE           = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_RED   = 2'd1,
    LED_GREEN = 2'd2,
    LED_NONE  = 2'd3
  } led_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  channel;
    logic [7:0]  position;
    logic [15:0] duration_ms;
    logic [31:0] now_ms;
    logic        bank;
    logic [1:0]  rail_status;
    logic        regulated;
  } in_item_t;

  typedef struct packed {
    logic       is_led_report;
    logic [1:0] bank_led;
    logic [4:0] channel_res;
    logic [7:0] pulse_width;
    logic       pulse_on;
    logic       last;
  } out_item_t;

  // One channel record as held in the channel memory.
  typedef struct packed {
    logic [7:0]  target;
    logic [7:0]  start;
    logic [15:0] duration;
    logic [31:0] start_time;
    logic [7:0]  current;
  } chan_rec_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  start_pos;
    logic [7:0]  target;
    logic [31:0] elapsed;
    logic [15:0] duration;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] pos;
  } div_rsp_t;

endpackage
`default_nettype wire

### src/servo_bank_pulse_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// servo_bank_pulse_controller_core
// Multichannel servo motion and pulse controller with two power banks.
// ----------------------------------------------------------------------------
// Per-channel motion records live in one RAM of CHANNELS entries and are
// cleared by a sweep over every entry after reset, during which no input
// is accepted. A set target passes through the read and set states back to
// idle; a power report is answered in idle with a registered LED report.
// A run frame handles the bank's channels one after another: each channel
// reads its record, runs a bit-serial interpolation divide in the shared
// divider, writes back if the channel is a servo and hands over its pulse result.
module servo_bank_pulse_controller_core
  import sbpc_pkg::*;
#(
  parameter int unsigned CHANNELS  = 24,
  parameter int unsigned BANK_SIZE = 12
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [23:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(CHANNELS);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_READ  = 8'b0000_0100,
    ST_SET   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_WAIT  = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_NEXT  = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  in_item_t    item_q, item_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW:0]   stop_q, stop_d;
  logic [1:0]  pok_q, pok_d, lock_q, lock_d;
  logic        ovr_q;
  logic [23:0] mask_q;
  logic [6:0]  margin_q;
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;
  logic [7:0]  newpos_q, newpos_d;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  chan_rec_t   wrec, rrec;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        servo;
  logic [7:0]  lim, clamped, pos1;

  sbpc_ram #(.Width(ChanMemW), .Depth(CHANNELS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wrec), .raddr_i(raddr), .rdata_o(rrec)
  );

  sbpc_interp u_interp (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign servo = ({{(32-AW){1'b0}}, addr_q} < 32'd24) ? mask_q[addr_q[4:0]] : 1'b0;
  assign lim   = 8'd255 - {1'b0, margin_q};
  assign pos1  = (drsp.pos > lim) ? lim : drsp.pos;
  assign clamped = (pos1 < {1'b0, margin_q}) ? {1'b0, margin_q} : pos1;
  assign raddr = addr_q;
  assign in_ready_o  = (state_q == ST_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    dreq.start     = (state_q == ST_DIV);
    dreq.start_pos = rrec.start;
    dreq.target    = rrec.target;
    dreq.elapsed   = item_q.now_ms - rrec.start_time;
    dreq.duration  = rrec.duration;
  end

  always_comb begin
    logic [AW:0] f, s;
    state_d = state_q; item_d = item_q; addr_d = addr_q; stop_d = stop_q;
    pok_d = pok_q; lock_d = lock_q; ov_d = ov_q; out_d = out_q; newpos_d = newpos_q;
    we = 1'b0; waddr = addr_q; wrec = rrec;
    f = in_data_i.bank ? (AW+1)'(BANK_SIZE) : '0;
    s = f + (AW+1)'(BANK_SIZE);
    if (out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1; wrec = '0;
        addr_d = addr_q + 1'b1;
        if ({1'b0, addr_q} == (AW+1)'(CHANNELS - 1)) begin
          state_d = ST_IDLE; addr_d = '0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          item_d = in_data_i;
          unique case (opcode_e'(in_data_i.opcode))
            OP_SET_TARGET: begin
              if ({1'b0, in_data_i.channel} < 6'(CHANNELS)) begin
                addr_d = AW'(in_data_i.channel);
                state_d = ST_READ;
              end
            end
            OP_POWER: begin
              pok_d[in_data_i.bank] = 1'b0;
              out_d = '0; out_d.is_led_report = 1'b1; out_d.last = 1'b1;
              if (in_data_i.regulated) begin
                out_d.bank_led = LED_GREEN;
              end else begin
                pok_d[in_data_i.bank] = (in_data_i.rail_status == 2'd1) ||
                                        (in_data_i.rail_status == 2'd2);
                out_d.bank_led = in_data_i.rail_status[0] ? LED_RED : LED_OFF;
                if ((in_data_i.rail_status == 2'd0) || (in_data_i.rail_status == 2'd3))
                  lock_d[in_data_i.bank] = 1'b1;
              end
              ov_d = 1'b1;
            end
            OP_RUN_FRAME: begin
              stop_d = (s > (AW+1)'(CHANNELS)) ? (AW+1)'(CHANNELS) : s;
              if (f < (AW+1)'(CHANNELS)) begin
                addr_d = AW'(f);
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = (opcode_e'(item_q.opcode) == OP_SET_TARGET) ? ST_SET : ST_DIV;
      end
      ST_SET: begin
        we = 1'b1;
        wrec.target     = item_q.position;
        wrec.start      = rrec.current;
        wrec.start_time = item_q.now_ms;
        wrec.duration   = ((item_q.duration_ms < 16'(MinMotionMs)) ||
                           (item_q.position == rrec.current)) ? 16'd0 : item_q.duration_ms;
        lock_d[({1'b0, addr_q} < (AW+1)'(BANK_SIZE)) ? 1'b0 : 1'b1] = 1'b0;
        state_d = ST_IDLE;
      end
      ST_DIV: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (drsp.done) begin
          newpos_d = servo ? clamped : rrec.current;
          we = servo;
          wrec.current = clamped;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          out_d = '0;
          out_d.channel_res = 5'(addr_q);
          out_d.pulse_width = newpos_q;
          out_d.pulse_on = servo && (pok_q[item_q.bank] || ovr_q) && !lock_q[item_q.bank];
          out_d.last = ({1'b0, addr_q} + 1'b1) == stop_q;
          ov_d = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (out_d.last) begin
          state_d = ST_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; addr_q <= '0; pok_q <= 2'b00; lock_q <= 2'b11;
      ov_q <= 1'b0; ovr_q <= 1'b0; mask_q <= '0; margin_q <= '0;
    end else begin
      state_q <= state_d; addr_q <= addr_d; pok_q <= pok_d; lock_q <= lock_d;
      ov_q <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_POWER_OVERRIDE: ovr_q    <= cfg_data_i[0];
          CFG_SERVO_MASK:     mask_q   <= cfg_data_i;
          CFG_END_MARGIN:     margin_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; stop_q <= stop_d; out_q <= out_d; newpos_q <= newpos_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(out_data_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SET) |=> (state_q == ST_IDLE))
    else $error("set target did not complete");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == ST_WAIT))
    else $error("divider finished out of turn");
endmodule
`default_nettype wire

### src/sbpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### src/sbpc_interp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpc_interp
// Truncating linear interpolation, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbpc_interp
  import sbpc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic [23:0] prod_q, prod_d;   // delta * elapsed, elapsed < duration
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [7:0]  quo_q, quo_d;
  logic [7:0]  base_q, base_d;
  logic        down_q, down_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [7:0]  res_q, res_d;
  logic [16:0] trial;
  logic [7:0]  delta;
  logic        dn;

  assign dn    = req_i.target < req_i.start_pos;
  assign delta = dn ? (req_i.start_pos - req_i.target) : (req_i.target - req_i.start_pos);
  assign trial = {rem_q, prod_q[23]} - {1'b0, div_q};

  // Quotient fits in 8 bits because elapsed < duration.
  always_comb begin
    prod_d = prod_q; rem_d = rem_q; div_d = div_q; quo_d = quo_q;
    base_d = base_q; down_d = down_q; cnt_d = cnt_q; busy_d = busy_q;
    done_d = 1'b0; res_d = res_q;
    if (req_i.start) begin
      if ((req_i.duration == 16'd0) || (req_i.elapsed >= {16'd0, req_i.duration})) begin
        res_d  = req_i.target;
        done_d = 1'b1;
      end else begin
        prod_d = delta * req_i.elapsed[15:0];
        rem_d  = 16'd0;
        div_d  = req_i.duration;
        base_d = req_i.start_pos;
        down_d = dn;
        cnt_d  = 5'd24;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!trial[16]) begin
        rem_d = trial[15:0];
      end else begin
        rem_d = {rem_q[14:0], prod_q[23]};
      end
      prod_d = {prod_q[22:0], 1'b0};
      quo_d  = {quo_q[6:0], ~trial[16]};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = down_q ? (base_q - {quo_q[6:0], ~trial[16]})
                        : (base_q + {quo_q[6:0], ~trial[16]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d; rem_q <= rem_d; div_q <= div_d; quo_q <= quo_d;
    base_q <= base_d; down_q <= down_d; res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pos  = res_q;
endmodule
`default_nettype wire

### test/tb_servo_bank_pulse_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_servo_bank_pulse_controller_core
// Self-checking bench for the servo bank pulse controller core.
// ----------------------------------------------------------------------------
// A directed table covers reset values, power report codes, the unused opcode,
// out-of-range channels, wrapped time stamps and margin clamping. Random motion
// and frame sequences follow under several register settings. Every pulse and
// LED transaction is compared with a behavioral model of the controller.
// ----------------------------------------------------------------------------
module tb_servo_bank_pulse_controller_core;
  import sbpc_pkg::*;

  localparam int unsigned NumChan = 24;
  localparam int unsigned BankSize = 12;
  localparam int unsigned CycleLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CFG_POWER_OVERRIDE;
  logic [23:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  servo_bank_pulse_controller_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // Model state of the controller.
  logic [7:0] m_target [NumChan];
  logic [7:0] m_start [NumChan];
  logic [15:0] m_dur [NumChan];
  logic [31:0] m_t0 [NumChan];
  logic [7:0] m_cur [NumChan];
  logic m_pwr_ok [2];
  logic m_lock [2];
  logic m_override;
  logic [23:0] m_mask;
  logic [6:0] m_margin;

  out_item_t pulse_queue [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] moved_position(int c, logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] pos;
    logic [31:0] lim;
    elapsed = now - m_t0[c];
    if (m_dur[c] == 0 || elapsed >= {16'd0, m_dur[c]}) pos = 32'(m_target[c]);
    else if (m_target[c] >= m_start[c])
      pos = m_start[c] + ((m_target[c] - m_start[c]) * elapsed) / m_dur[c];
    else pos = m_start[c] - ((m_start[c] - m_target[c]) * elapsed) / m_dur[c];
    lim = 255 - m_margin;
    if (pos > lim) pos = lim;
    if (pos < m_margin) pos = m_margin;
    return pos[7:0];
  endfunction

  task automatic predict_transaction(in_item_t it);
    out_item_t o;
    int c;
    int b;
    logic pw;
    logic [15:0] d;
    b = it.bank;
    case (opcode_e'(it.opcode))
      OP_SET_TARGET: begin
        c = it.channel;
        if (c < NumChan) begin
          d = it.duration_ms;
          if (d < MinMotionMs || it.position == m_cur[c]) d = '0;
          m_target[c] = it.position;
          m_start[c] = m_cur[c];
          m_t0[c] = it.now_ms;
          m_dur[c] = d;
          m_lock[c < BankSize ? 0 : 1] = 1'b0;
        end
      end
      OP_POWER: begin
        o = '0;
        o.is_led_report = 1'b1;
        o.last = 1'b1;
        m_pwr_ok[b] = 1'b0;
        if (it.regulated) o.bank_led = LED_GREEN;
        else begin
          if (it.rail_status == 1 || it.rail_status == 2) m_pwr_ok[b] = 1'b1;
          o.bank_led = (it.rail_status == 1 || it.rail_status == 3) ? LED_RED : LED_OFF;
          if (it.rail_status == 0 || it.rail_status == 3) m_lock[b] = 1'b1;
        end
        pulse_queue.push_back(o);
      end
      OP_RUN_FRAME: begin
        pw = m_pwr_ok[b] || m_override;
        for (c = b * BankSize; c < b * BankSize + BankSize; c++)
          if (m_mask[c]) m_cur[c] = moved_position(c, it.now_ms);
        for (c = b * BankSize; c < b * BankSize + BankSize; c++) begin
          o = '0;
          o.channel_res = c[4:0];
          o.pulse_width = m_cur[c];
          o.pulse_on = m_mask[c] && pw && !m_lock[b];
          o.last = (c == b * BankSize + BankSize - 1);
          pulse_queue.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(cfg_index_e idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POWER_OVERRIDE: m_override = val[0];
      CFG_SERVO_MASK: m_mask = val;
      CFG_END_MARGIN: m_margin = val[6:0];
      default: ;
    endcase
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pulse_queue.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // Valid stays high after acceptance until the next item or a drain replaces it.
  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_transaction(it);
    @(negedge clk_i);
  endtask

  function automatic in_item_t mk(opcode_e op, int ch, int pos, int dur, logic [31:0] now,
                                  int bk, int rail, int reg_bit);
    in_item_t it;
    it.opcode = op;
    it.channel = ch[4:0];
    it.position = pos[7:0];
    it.duration_ms = dur[15:0];
    it.now_ms = now;
    it.bank = bk[0];
    it.rail_status = rail[1:0];
    it.regulated = reg_bit[0];
    return it;
  endfunction

  function automatic in_item_t random_item(logic [31:0] clock_ms);
    in_item_t it;
    int r;
    it = '0;
    it.channel = 5'($urandom_range(0, NumChan - 1));
    it.position = 8'($urandom);
    it.duration_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    it.now_ms = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_ms;
    it.bank = 1'($urandom);
    it.rail_status = 2'($urandom);
    it.regulated = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      it.opcode = OP_UNUSED;
      it.channel = 5'($urandom);
    end else if (r < 8) begin
      it.opcode = OP_SET_TARGET;
      it.channel = 5'($urandom_range(NumChan, 31));
    end else if (r < 50) it.opcode = OP_SET_TARGET;
    else if (r < 62) it.opcode = OP_POWER;
    else it.opcode = OP_RUN_FRAME;
    return it;
  endfunction

  // Result side: random stalls, compare against the oldest expectation.
  always @(negedge clk_i) begin
    if (quiet || $urandom_range(0, 5) != 0) out_ready_i <= 1'b1;
    else begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pulse_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %p", out_data_o);
      end else begin
        out_item_t want;
        want = pulse_queue.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Directed rows; an expected value is given only where the row has one
  // obvious result (LED reports from reset, bank locked after reset).
  typedef struct {
    in_item_t it;
    bit has_exp;
    out_item_t exp_first;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    in_item_t it;
    logic [31:0] clock_ms;
    int n;
    int phase;
    logic [23:0] masks [4];
    foreach (m_target[i]) begin
      m_target[i] = 0; m_start[i] = 0; m_dur[i] = 0; m_t0[i] = 0; m_cur[i] = 0;
    end
    m_pwr_ok[0] = 0; m_pwr_ok[1] = 0; m_lock[0] = 1; m_lock[1] = 1;
    m_override = 0; m_mask = 0; m_margin = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // From reset the bank is locked and the zero positions clamp up to the margin.
    rw.has_exp = 1;
    rw.it = mk(OP_RUN_FRAME, 0, 0, 0, 32'd0, 0, 0, 0);
    rw.exp_first = '{is_led_report: 0, bank_led: 0, channel_res: 0, pulse_width: 127,
                     pulse_on: 0, last: 0};
    rows.push_back(rw);
    rw.it = mk(OP_POWER, 0, 0, 0, 32'd0, 1, 3, 1);
    rw.exp_first = '{1, LED_GREEN, 0, 0, 0, 1};
    rows.push_back(rw);
    rw.it = mk(OP_POWER, 0, 0, 0, 32'd0, 0, 1, 0);
    rw.exp_first = '{1, LED_RED, 0, 0, 0, 1};
    rows.push_back(rw);
    rw.it = mk(OP_POWER, 0, 0, 0, 32'd0, 1, 2, 0);
    rw.exp_first = '{1, LED_OFF, 0, 0, 0, 1};
    rows.push_back(rw);
    rw.has_exp = 0;
    rows.push_back('{mk(OP_UNUSED, 31, 255, 65535, 32'hFFFF_FFFF, 1, 3, 1), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 31, 9, 100, 32'd0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 0, 255, 65535, 32'd100, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 11, 200, 29, 32'd100, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 12, 0, 300, 32'd100, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 23, 128, 30, 32'hFFFF_FFF0, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_SET_TARGET, 13, 77, 300, 32'd100, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_RUN_FRAME, 0, 0, 0, 32'd150, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_RUN_FRAME, 0, 0, 0, 32'd250, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_RUN_FRAME, 0, 0, 0, 32'd50, 1, 0, 0), 0, '0});
    rows.push_back('{mk(OP_POWER, 0, 0, 0, 32'd0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_RUN_FRAME, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0), 0, '0});

    write_reg(CFG_SERVO_MASK, 24'hFFFFFF);
    write_reg(CFG_END_MARGIN, 24'd127);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        // Earlier results are all taken before the block accepts this row, so
        // the head of the queue is the model's first result for the row.
        send_item(rows[i].it);
        if (pulse_queue.size() == 0 || pulse_queue[0] !== rows[i].exp_first) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %p got %p", i, rows[i].exp_first,
                     pulse_queue[0]);
        end
      end else send_item(rows[i].it);
      if (i == 10) begin
        drain_and_settle();
        write_reg(CFG_END_MARGIN, 24'd0);
        write_reg(CFG_POWER_OVERRIDE, 24'd1);
      end
    end
    drain_and_settle();

    masks[0] = 24'hFFFFFF; masks[1] = 24'h0; masks[2] = 24'hA5A5A5; masks[3] = 24'h5A5A5A;
    clock_ms = 32'd1000;
    for (phase = 0; phase < 5; phase++) begin
      write_reg(CFG_POWER_OVERRIDE, 24'(phase[0]));
      write_reg(CFG_SERVO_MASK, (phase == 4) ? 24'($urandom) : masks[phase % 4]);
      write_reg(CFG_END_MARGIN, (phase == 2) ? 24'd127 : (phase == 3) ? 24'd0
                                 : 24'($urandom_range(0, 40)));
      quiet = (phase == 4);
      for (n = 0; n < 34; n++) begin
        clock_ms += $urandom_range(0, 120);
        it = random_item(clock_ms);
        send_item(it);
      end
      // Hold the sender until every expected transaction has arrived.
      drain_and_settle();
    end

    drain_and_settle();
    if (mismatches == 0 && pulse_queue.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
